// ===== src/sktbl_pkg.sv =====
// ----------------------------------------------------------------------------
// sktbl_pkg: shared types and constants for the sorted key table
// Entry layout, cell commands, per-cell compare flags and request codes.
// ----------------------------------------------------------------------------
package sktbl_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = 3;
    localparam int CNT_W    = 4;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_REQ,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER,
        CELL_CLEAR
    } cell_cmd_t;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic        [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic above;
        logic eq;
        logic ge;
    } cell_flags_t;

endpackage

// ===== src/sktbl_cell.sv =====
// ----------------------------------------------------------------------------
// sktbl_cell: one slot of the sorted key table
// Holds one entry, compares it against the request key and loads from the
// request or from either neighbor on command.
// ----------------------------------------------------------------------------
module sktbl_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sktbl_pkg::cell_cmd_t            cmd,
    input  logic signed [sktbl_pkg::KEY_W-1:0] req_key,
    input  logic        [sktbl_pkg::VAL_W-1:0] req_value,
    input  sktbl_pkg::entry_t               lower_entry,
    input  sktbl_pkg::entry_t               upper_entry,
    output sktbl_pkg::entry_t               entry,
    output sktbl_pkg::cell_flags_t          flags
);
    import sktbl_pkg::*;

    logic                    valid_reg, valid_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic        [VAL_W-1:0] value_reg, value_next;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        unique case (cmd)
            CELL_HOLD: begin
            end
            CELL_LOAD_REQ: begin
                valid_next = 1'b1;
                key_next   = req_key;
                value_next = req_value;
            end
            CELL_FROM_LOWER: begin
                valid_next = lower_entry.valid;
                key_next   = lower_entry.key;
                value_next = lower_entry.value;
            end
            CELL_FROM_UPPER: begin
                valid_next = upper_entry.valid;
                key_next   = upper_entry.key;
                value_next = upper_entry.value;
            end
            CELL_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

    assign flags.above = !valid_reg || (key_reg > req_key);
    assign flags.eq    = valid_reg && (key_reg == req_key);
    assign flags.ge    = valid_reg && (key_reg >= req_key);

endmodule

// ===== src/sorted_key_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_core: sorted key/value table with insert, search, remove
// Result: registered in the cycle after the request transfer.
// Throughput: 1 request per cycle unless an unread result drops s_ready;
// every cell compares the broadcast key; affected ones shift in the same cycle.
// Reset: synchronous active-low aresetn empties the table and the result slot.
// ----------------------------------------------------------------------------
module sorted_key_table_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sktbl_pkg::FUNC_W-1:0]       s_func,
    input  logic signed [sktbl_pkg::KEY_W-1:0] s_key,
    input  logic [sktbl_pkg::VAL_W-1:0]        s_entry_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic [sktbl_pkg::IDX_W-1:0]        m_position,
    output logic [sktbl_pkg::VAL_W-1:0]        m_found_value,
    output logic [sktbl_pkg::CNT_W-1:0]        m_entry_count
);
    import sktbl_pkg::*;

    entry_t      entries [CAPACITY];
    entry_t      lower_in [CAPACITY];
    entry_t      upper_in [CAPACITY];
    cell_flags_t flags [CAPACITY];
    cell_cmd_t   cmds [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;

    logic             out_valid_reg, out_valid_next;
    logic             ok_reg, ok_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] fv_reg, fv_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;

    logic             accept;
    logic             full;
    logic             hit;
    logic [IDX_W-1:0] ins_pos;
    logic [IDX_W-1:0] hit_pos;
    logic [VAL_W-1:0] hit_value;
    func_t            func;

    assign func    = func_t'(s_func);
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign lower_in[g] = '0;
            end else begin : g_mid
                assign lower_in[g] = entries[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign upper_in[g] = '0;
            end else begin : g_inner
                assign upper_in[g] = entries[g+1];
            end
            assign valid_vec[g] = entries[g].valid;

            sktbl_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmds[g]),
                .req_key     (s_key),
                .req_value   (s_entry_value),
                .lower_entry (lower_in[g]),
                .upper_entry (upper_in[g]),
                .entry       (entries[g]),
                .flags       (flags[g])
            );
        end
    endgenerate

    // encoded indices of the leading edges of the above and equal runs
    always_comb begin
        hit       = 1'b0;
        ins_pos   = '0;
        hit_pos   = '0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (flags[i].eq) begin
                hit = 1'b1;
            end
            if (flags[i].above && (i == 0 || !flags[(i == 0) ? 0 : i-1].above)) begin
                ins_pos = ins_pos | IDX_W'(i);
            end
            if (flags[i].eq && (i == 0 || !flags[(i == 0) ? 0 : i-1].eq)) begin
                hit_pos   = hit_pos | IDX_W'(i);
                hit_value = hit_value | entries[i].value;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cmds[i] = CELL_HOLD;
            if (accept) begin
                unique case (func)
                    FUNC_INSERT: begin
                        if (!full) begin
                            if (i > 0 && flags[(i == 0) ? 0 : i-1].above) begin
                                cmds[i] = CELL_FROM_LOWER;
                            end else if (flags[i].above) begin
                                cmds[i] = CELL_LOAD_REQ;
                            end
                        end
                    end
                    FUNC_SEARCH: begin
                    end
                    FUNC_REMOVE: begin
                        if (hit && flags[i].ge) begin
                            cmds[i] = CELL_FROM_UPPER;
                        end
                    end
                    FUNC_CLEAR: begin
                        cmds[i] = CELL_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        pos_next       = pos_reg;
        fv_next        = fv_reg;
        out_count_next = out_count_reg;
        count_next     = count_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            out_valid_next = 1'b1;
            ok_next        = 1'b0;
            pos_next       = '0;
            fv_next        = '0;
            unique case (func)
                FUNC_INSERT: begin
                    if (!full) begin
                        ok_next    = 1'b1;
                        pos_next   = ins_pos;
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_SEARCH: begin
                    if (hit) begin
                        ok_next  = 1'b1;
                        pos_next = hit_pos;
                        fv_next  = hit_value;
                    end
                end
                FUNC_REMOVE: begin
                    if (hit) begin
                        ok_next    = 1'b1;
                        pos_next   = hit_pos;
                        count_next = count_reg - 1'b1;
                    end
                end
                FUNC_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
            out_count_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
        ok_reg        <= ok_next;
        pos_reg       <= pos_next;
        fv_reg        <= fv_next;
        out_count_reg <= out_count_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_ok          = ok_reg;
    assign m_position    = pos_reg;
    assign m_found_value = fv_reg;
    assign m_entry_count = out_count_reg;

    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(count_reg))
        else $error("fill count differs from occupied cells");

    a_fail_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !ok_reg) |-> (pos_reg == '0 && fv_reg == '0))
        else $error("failed result carries nonzero position or value");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_CLEAR) |=> (count_reg == '0 && valid_vec == '0))
        else $error("clear left entries behind");

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_INSERT && full) |=> $stable(count_reg))
        else $error("insert into full table changed the count");

endmodule
